@@ hw/rtl/billboard_sprite_projection_clip_macros.svh @@
// Assertion macros shared by the checker
`ifndef BILLBOARD_SPRITE_PROJECTION_CLIP_MACROS_SVH
`define BILLBOARD_SPRITE_PROJECTION_CLIP_MACROS_SVH

// Same-cycle implication, idle in reset
`define BBSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbsp check failed");

// Next-cycle implication, idle in reset
`define BBSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbsp check failed");

`endif

@@ hw/rtl/bbsp_pkg.sv @@
package bbsp_pkg;

  // Clamp limits for screen and frame sizes
  localparam int MAX_SCREEN = 1024;
  localparam int MAX_FRAME  = 256;

  // Shared divider: numerator and divisor widths
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 37;
  localparam int DIV_CW = 6;

  // Shared multiplier operand widths
  localparam int MUL_AW = 40;
  localparam int MUL_BW = 17;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // Working width of signed screen quantities
  localparam int SWID = 34;

  // Near plane: 0.05 taken as 13/256, in Q.22
  localparam logic signed [SWID-1:0] NEAR_LIMIT = 34'sd212992;

  // 33 * 2^14 and 66 * 2^14
  localparam logic signed [39:0] HALF_SCALE = 40'sd540672;
  localparam logic [DIV_DW-1:0]  FULL_SCALE = 37'd1081344;

  typedef enum logic [1:0] {
    REG_VIEW_COS,
    REG_VIEW_SIN,
    REG_SCREEN_W,
    REG_SCREEN_H
  } reg_idx_t;

  localparam logic OP_SETUP = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Divider launch
  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] iters;
  } div_req_t;

endpackage

@@ hw/rtl/bbsp_div.sv @@
module bbsp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  bbsp_pkg::div_req_t         req,
  input  logic [bbsp_pkg::DIV_NW-1:0] num,
  input  logic [bbsp_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [bbsp_pkg::DIV_NW-1:0] quo
);
  import bbsp_pkg::*;

  logic              busy;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] shf;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   rem_next;
  logic              q_bit;

  // One restoring step: numerator is left aligned by the caller
  always_comb begin
    rem_sh = {rem, shf[DIV_NW-1]};
    q_bit  = (rem_sh >= {1'b0, den_r});
    rem_next = q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= req.iters;
        rem   <= '0;
        shf   <= num;
        quo   <= '0;
        den_r <= den;
      end else if (busy) begin
        rem <= rem_next[DIV_DW-1:0];
        shf <= {shf[DIV_NW-2:0], 1'b0};
        quo <= {quo[DIV_NW-2:0], q_bit};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/bbsp_mul.sv @@
module bbsp_mul (
  input  logic                               clk,
  input  logic signed [bbsp_pkg::MUL_AW-1:0] a,
  input  logic signed [bbsp_pkg::MUL_BW-1:0] b,
  output logic signed [bbsp_pkg::MUL_PW-1:0] prod
);
  import bbsp_pkg::*;

  // Registered signed product
  always_ff @(posedge clk) begin
    prod <= MUL_PW'(a) * MUL_PW'(b);
  end

endmodule

@@ hw/rtl/billboard_sprite_projection_clip.sv @@
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | operation, rel_x..wall_top
// out     | output    | out_valid/out_stall | visible, draw, texel_index, box, depth
// cfg     | input     | APB psel/penable    | view_cos, view_sin, screen size
//
// Setup item: multiplies plus five passes of the shared divider (48 steps for
// the screen centre, 32 for each span and row); a sprite too near skips the divider.
// Pixel query: two 20 step divisions; a rejected pixel skips them.
// Reset is synchronous; no sprite is set up after it.
// A stalled result holds in the output register; the next transaction is
// taken meanwhile, and the sequencer waits only to hand over a new result.
module billboard_sprite_projection_clip (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] rel_x,
  input  logic signed [15:0] rel_y,
  input  logic signed [15:0] rel_z,
  input  logic [15:0]        sprite_height,
  input  logic [8:0]         frame_width,
  input  logic [8:0]         frame_height,
  input  logic [9:0]         pixel_x,
  input  logic [9:0]         pixel_y,
  input  logic [15:0]        wall_depth,
  input  logic signed [15:0] wall_top,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               visible,
  output logic               draw,
  output logic [15:0]        texel_index,
  output logic [9:0]         box_left,
  output logic [9:0]         box_right,
  output logic [9:0]         box_top,
  output logic [9:0]         box_bottom,
  output logic [15:0]        sprite_depth
);
  import bbsp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8,
    ST_W_SX, ST_DSH, ST_W_SH, ST_MSW, ST_DSW, ST_W_SW, ST_MT, ST_DT,
    ST_W_T, ST_DB, ST_W_B, ST_BOX, ST_QCHK, ST_QDX, ST_QWX, ST_QDY,
    ST_QWY, ST_QMI, ST_QIDX, ST_OUT
  } state_t;

  typedef struct packed {
    logic        visible;
    logic        draw;
    logic [15:0] texel;
    logic [9:0]  left;
    logic [9:0]  right;
    logic [9:0]  top;
    logic [9:0]  bottom;
    logic [15:0] depth;
  } res_t;

  state_t state;

  // configuration registers
  logic signed [15:0] cfg_cos;
  logic signed [15:0] cfg_sin;
  logic [10:0]        cfg_w;
  logic [10:0]        cfg_h;

  // latched transaction
  logic signed [15:0] dx, dy, dz;
  logic [15:0]        hgt;
  logic [8:0]         fw_in, fh_in;
  logic [9:0]         px, py;
  logic [15:0]        wd;
  logic signed [15:0] wt;

  // stored sprite
  logic [9:0]  box_l, box_r, box_t, box_b;
  logic [15:0] depth_r;
  logic [8:0]  frame_w_r, frame_h_r;
  logic        sprite_ok;

  // working registers
  logic signed [MUL_PW-1:0] p_a;
  logic signed [SWID-1:0]   depth_raw, lat;
  logic [15:0]              d;
  logic signed [39:0]       numx;
  logic signed [SWID-1:0]   sx, sh, sw, top, bot;
  logic                     neg;
  logic [8:0]               cx, cy;
  res_t                     res;

  // shared units
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  div_req_t                 div_req;
  logic [DIV_NW-1:0]        div_num;
  logic [DIV_DW-1:0]        div_den;
  logic                     div_done;
  logic [DIV_NW-1:0]        quo;

  logic [10:0] w_c, h_c, w_m1, h_m1;
  logic [8:0]  fw_c, fh_c;
  logic signed [MUL_PW-1:0] prod_mag, tnum, tnum_mag;
  logic signed [SWID-1:0]   q_s;
  logic signed [SWID-1:0]   left, right, lc, rc, tc, bc;
  logic                     box_ok;
  logic                     q_reject;
  logic                     accept;

  bbsp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  bbsp_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .num(div_num), .den(div_den),
    .done(div_done), .quo(quo)
  );

  assign pready   = 1'b1;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // register read
  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_VIEW_COS: prdata = 32'(cfg_cos);
      REG_VIEW_SIN: prdata = 32'(cfg_sin);
      REG_SCREEN_W: prdata = {21'd0, cfg_w};
      REG_SCREEN_H: prdata = {21'd0, cfg_h};
      default:      prdata = '0;
    endcase
  end

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cos <= 16'sd16384;
      cfg_sin <= '0;
      cfg_w   <= 11'd320;
      cfg_h   <= 11'd200;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_VIEW_COS: cfg_cos <= pwdata[15:0];
        REG_VIEW_SIN: cfg_sin <= pwdata[15:0];
        REG_SCREEN_W: cfg_w   <= pwdata[10:0];
        REG_SCREEN_H: cfg_h   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    w_c  = (cfg_w < 11'd2) ? 11'd2 : ((cfg_w > 11'(MAX_SCREEN)) ? 11'(MAX_SCREEN) : cfg_w);
    h_c  = (cfg_h < 11'd2) ? 11'd2 : ((cfg_h > 11'(MAX_SCREEN)) ? 11'(MAX_SCREEN) : cfg_h);
    w_m1 = w_c - 11'd1;
    h_m1 = h_c - 11'd1;
    fw_c = (fw_in == 9'd0) ? 9'd1 : ((fw_in > 9'(MAX_FRAME)) ? 9'(MAX_FRAME) : fw_in);
    fh_c = (fh_in == 9'd0) ? 9'd1 : ((fh_in > 9'(MAX_FRAME)) ? 9'(MAX_FRAME) : fh_in);
  end

  // magnitudes and signed quotient
  always_comb begin
    prod_mag = prod[MUL_PW-1] ? -prod : prod;
    tnum     = p_a - prod;
    tnum_mag = tnum[MUL_PW-1] ? -tnum : tnum;
    q_s      = neg ? -$signed(quo[SWID-1:0]) : $signed(quo[SWID-1:0]);
  end

  // box from centre and spans, then clipping
  always_comb begin
    left   = sx - (sw >>> 1);
    right  = left + sw;
    lc     = (left < 0) ? '0 : left;
    rc     = (right > $signed({23'd0, w_m1})) ? $signed({23'd0, w_m1}) : right;
    tc     = (top < 0) ? '0 : top;
    bc     = (bot > $signed({23'd0, h_m1})) ? $signed({23'd0, h_m1}) : bot;
    box_ok = (rc > lc) && (bc > tc);
  end

  // pixel outside, no sprite, or hidden behind a nearer wall
  always_comb begin
    q_reject = !sprite_ok || (box_r <= box_l) || (box_b <= box_t) ||
               (px < box_l) || (px >= box_r) || (py < box_t) || (py >= box_b) ||
               ((wd < depth_r) && ($signed({1'b0, py, 8'd0}) >= 19'(wt)));
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_M1:   begin mul_a = MUL_AW'(cfg_cos); mul_b = MUL_BW'(dx); end
      ST_M2:   begin mul_a = MUL_AW'(cfg_sin); mul_b = MUL_BW'(dy); end
      ST_M3:   begin mul_a = MUL_AW'(cfg_cos); mul_b = MUL_BW'(dy); end
      ST_M4:   begin mul_a = MUL_AW'(cfg_sin); mul_b = MUL_BW'(dx); end
      ST_M7:   begin mul_a = numx; mul_b = $signed({6'd0, w_c}); end
      ST_W_SX: begin mul_a = $signed({29'd0, h_c}); mul_b = $signed({1'b0, hgt}); end
      ST_MSW:  begin mul_a = MUL_AW'(sh); mul_b = $signed({8'd0, fw_c}); end
      ST_W_SW: begin mul_a = $signed({30'd0, h_c[10:1]}); mul_b = $signed({1'b0, d}); end
      ST_MT:   begin
        mul_a = MUL_AW'(18'(dz) + $signed({2'b0, hgt}));
        mul_b = $signed({6'd0, h_c});
      end
      ST_W_T:  begin mul_a = MUL_AW'(dz); mul_b = $signed({6'd0, h_c}); end
      ST_QCHK: begin
        mul_a = $signed({30'd0, px - box_l}); mul_b = $signed({8'd0, frame_w_r});
      end
      ST_QWX:  begin
        mul_a = $signed({30'd0, py - box_t}); mul_b = $signed({8'd0, frame_h_r});
      end
      ST_QMI:  begin mul_a = $signed({31'd0, cy}); mul_b = $signed({8'd0, frame_w_r}); end
      default: ;
    endcase
  end

  // divider launch
  always_comb begin
    div_req = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      ST_M8: begin
        div_req = '{start: 1'b1, iters: DIV_CW'(48)};
        div_num = prod_mag[DIV_NW-1:0];
        div_den = DIV_DW'(d) * FULL_SCALE;
      end
      ST_DSH: begin
        div_req = '{start: 1'b1, iters: DIV_CW'(32)};
        div_num = {prod[31:0], 16'd0};
        div_den = DIV_DW'(d);
      end
      ST_DSW: begin
        div_req = '{start: 1'b1, iters: DIV_CW'(32)};
        div_num = {prod[31:0], 16'd0};
        div_den = DIV_DW'(fh_c);
      end
      ST_DT, ST_DB: begin
        div_req = '{start: 1'b1, iters: DIV_CW'(32)};
        div_num = {tnum_mag[31:0], 16'd0};
        div_den = DIV_DW'(d);
      end
      ST_QDX: begin
        div_req = '{start: 1'b1, iters: DIV_CW'(20)};
        div_num = {prod[19:0], 28'd0};
        div_den = DIV_DW'(box_r - box_l);
      end
      ST_QDY: begin
        div_req = '{start: 1'b1, iters: DIV_CW'(20)};
        div_num = {prod[19:0], 28'd0};
        div_den = DIV_DW'(box_b - box_t);
      end
      default: ;
    endcase
  end

  // sequencer, sprite state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      sprite_ok <= 1'b0;
      box_l     <= '0;
      box_r     <= '0;
      box_t     <= '0;
      box_b     <= '0;
      depth_r   <= '0;
      frame_w_r <= 9'd1;
      frame_h_r <= 9'd1;
    end else begin
      // result handshake: load a new one or drop the taken one
      if (state == ST_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (accept) begin
          dx    <= rel_x;
          dy    <= rel_y;
          dz    <= rel_z;
          hgt   <= sprite_height;
          fw_in <= frame_width;
          fh_in <= frame_height;
          px    <= pixel_x;
          py    <= pixel_y;
          wd    <= wall_depth;
          wt    <= wall_top;
          res   <= '0;
          state <= (operation == OP_PIXEL) ? ST_QCHK : ST_M1;
        end
        ST_M1: state <= ST_M2;
        ST_M2: begin p_a <= prod; state <= ST_M3; end
        ST_M3: begin depth_raw <= SWID'(p_a + prod); state <= ST_M4; end
        ST_M4: begin p_a <= prod; state <= ST_M5; end
        ST_M5: begin
          lat <= SWID'(p_a - prod);
          if (depth_raw < NEAR_LIMIT) begin
            sprite_ok <= 1'b0;
            state     <= ST_OUT;
          end else begin
            d     <= (depth_raw[SWID-1:14] > 20'd65535) ? 16'hFFFF : depth_raw[29:14];
            state <= ST_M6;
          end
        end
        ST_M6: begin
          numx  <= (40'($signed({1'b0, d})) * HALF_SCALE) + (40'(lat) * 40'sd50);
          state <= ST_M7;
        end
        ST_M7: state <= ST_M8;
        ST_M8: begin neg <= prod[MUL_PW-1]; state <= ST_W_SX; end
        ST_W_SX: if (div_done) begin sx <= q_s; state <= ST_DSH; end
        ST_DSH: begin neg <= 1'b0; state <= ST_W_SH; end
        ST_W_SH: if (div_done) begin
          sh    <= (quo == '0) ? SWID'(1) : $signed(quo[SWID-1:0]);
          state <= ST_MSW;
        end
        ST_MSW: state <= ST_DSW;
        ST_DSW: state <= ST_W_SW;
        ST_W_SW: if (div_done) begin
          sw    <= (quo == '0) ? SWID'(1) : $signed(quo[SWID-1:0]);
          state <= ST_MT;
        end
        ST_MT: begin p_a <= prod; state <= ST_DT; end
        ST_DT: begin neg <= tnum[MUL_PW-1]; state <= ST_W_T; end
        ST_W_T: if (div_done) begin top <= q_s; state <= ST_DB; end
        ST_DB: begin neg <= tnum[MUL_PW-1]; state <= ST_W_B; end
        ST_W_B: if (div_done) begin bot <= q_s; state <= ST_BOX; end
        ST_BOX: begin
          sprite_ok <= box_ok;
          if (box_ok) begin
            box_l       <= lc[9:0];
            box_r       <= rc[9:0];
            box_t       <= tc[9:0];
            box_b       <= bc[9:0];
            depth_r     <= d;
            frame_w_r   <= fw_c;
            frame_h_r   <= fh_c;
            res.visible <= 1'b1;
            res.left    <= lc[9:0];
            res.right   <= rc[9:0];
            res.top     <= tc[9:0];
            res.bottom  <= bc[9:0];
            res.depth   <= d;
          end
          state <= ST_OUT;
        end
        ST_QCHK: state <= q_reject ? ST_OUT : ST_QDX;
        ST_QDX:  state <= ST_QWX;
        ST_QWX: if (div_done) begin
          cx    <= (quo >= DIV_NW'(frame_w_r)) ? (frame_w_r - 9'd1) : quo[8:0];
          state <= ST_QDY;
        end
        ST_QDY: state <= ST_QWY;
        ST_QWY: if (div_done) begin
          cy    <= (quo >= DIV_NW'(frame_h_r)) ? (frame_h_r - 9'd1) : quo[8:0];
          state <= ST_QMI;
        end
        ST_QMI: state <= ST_QIDX;
        ST_QIDX: begin
          res.draw  <= 1'b1;
          res.texel <= prod[15:0] + {7'd0, cx};
          state     <= ST_OUT;
        end
        ST_OUT: if (!out_valid || !out_stall) begin
          visible      <= res.visible;
          draw         <= res.draw;
          texel_index  <= res.texel;
          box_left     <= res.left;
          box_right    <= res.right;
          box_top      <= res.top;
          box_bottom   <= res.bottom;
          sprite_depth <= res.depth;
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/bbsp_checker.sv @@
`include "billboard_sprite_projection_clip_macros.svh"

module bbsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        visible,
  input logic        draw,
  input logic [15:0] texel_index,
  input logic [9:0]  box_left,
  input logic [9:0]  box_right,
  input logic [9:0]  box_top,
  input logic [9:0]  box_bottom,
  input logic [15:0] sprite_depth
);

  // a stalled result stays offered
  `BBSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // a transaction is either a setup or a pixel answer
  `BBSP_ASSERT_NOW(a_kind, out_valid, !(visible && draw))

  // a visible sprite has a non-empty box
  `BBSP_ASSERT_NOW(a_box, out_valid && visible,
                   (box_left < box_right) && (box_top < box_bottom))

  // non-visible results carry zero box_left, box_right and depth
  `BBSP_ASSERT_NOW(a_zero_box, out_valid && !visible,
                   (box_left == 10'd0) && (box_right == 10'd0) && (sprite_depth == 16'd0))

  // undrawn pixels carry no texel
  `BBSP_ASSERT_NOW(a_zero_texel, out_valid && !draw, texel_index == 16'd0)

endmodule

bind billboard_sprite_projection_clip bbsp_checker u_bbsp_checker (.*);

@@ dv/tb_billboard_sprite_projection_clip.sv @@
module tb_billboard_sprite_projection_clip;
  import bbsp_pkg::*;

  localparam int  SETTLE_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct {
    logic               op;
    logic signed [15:0] rx, ry, rz;
    logic [15:0]        hgt;
    logic [8:0]         fw, fh;
    logic [9:0]         px, py;
    logic [15:0]        wdepth;
    logic signed [15:0] wtop;
  } sprite_item_t;

  typedef struct {
    logic        visible;
    logic        draw;
    logic [15:0] texel;
    logic [9:0]  left, right, top, bottom;
    logic [15:0] depth;
  } sprite_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic operation = 1'b0;
  logic signed [15:0] rel_x = '0, rel_y = '0, rel_z = '0, wall_top = '0;
  logic [15:0] sprite_height = '0, wall_depth = '0;
  logic [8:0] frame_width = '0, frame_height = '0;
  logic [9:0] pixel_x = '0, pixel_y = '0;
  logic out_valid, out_stall = 1'b0;
  logic visible, draw;
  logic [15:0] texel_index, sprite_depth;
  logic [9:0] box_left, box_right, box_top, box_bottom;

  billboard_sprite_projection_clip dut (.*);

  always #2 clk = ~clk;

  // Predictor copy of configuration and sprite state
  longint view_c, view_s;
  logic [10:0] scr_w, scr_h;
  longint bl, br, bt, bb, bdepth, bfw, bfh;
  bit     sprite_ok;

  sprite_result_t pending_results[$];
  int     mismatches = 0;
  int     burst_left = 0;
  longint cycle_count = 0;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Projection / pixel lookup, updating the stored sprite
  function automatic sprite_result_t predict_sprite(sprite_item_t it);
    sprite_result_t r;
    longint dx, dy, dz, hg, fw, fh, w, h, draw_raw, lat, d, sx, sh, sw;
    longint top, bot, left, right, x, y, cx, cy;
    r = '{default: '0};
    if (it.op == OP_PIXEL) begin
      x = it.px;
      y = it.py;
      if (!sprite_ok || br <= bl || bb <= bt) return r;
      if (x < bl || x >= br || y < bt || y >= bb) return r;
      if (longint'(it.wdepth) < bdepth && 256 * y >= longint'(it.wtop)) return r;
      cx = clip((x - bl) * bfw / (br - bl), 0, bfw - 1);
      cy = clip((y - bt) * bfh / (bb - bt), 0, bfh - 1);
      r.draw = 1'b1;
      r.texel = 16'(cy * bfw + cx);
      return r;
    end
    dx = it.rx; dy = it.ry; dz = it.rz; hg = it.hgt;
    fw = clip(it.fw, 1, MAX_FRAME);
    fh = clip(it.fh, 1, MAX_FRAME);
    w = clip(scr_w, 2, MAX_SCREEN);
    h = clip(scr_h, 2, MAX_SCREEN);
    draw_raw = view_c * dx + view_s * dy;
    lat = view_c * dy - view_s * dx;
    sprite_ok = 0;
    // too close to or behind the eye
    if (draw_raw < 13 * 16384) return r;
    d = draw_raw >>> 14;
    if (d > 65535) d = 65535;
    sx = w * (66 * d * 16384 + 100 * lat) / (132 * d * 16384);
    sh = h * hg / d;
    if (sh < 1) sh = 1;
    sw = sh * fw / fh;
    if (sw < 1) sw = 1;
    top = ((h / 2) * d - (dz + hg) * h) / d;
    bot = ((h / 2) * d - dz * h) / d;
    left = sx - sw / 2;
    right = left + sw;
    if (left < 0) left = 0;
    if (right > w - 1) right = w - 1;
    if (top < 0) top = 0;
    if (bot > h - 1) bot = h - 1;
    if (right - left <= 0 || bot - top <= 0) return r;
    sprite_ok = 1;
    bl = left; br = right; bt = top; bb = bot;
    bdepth = d; bfw = fw; bfh = fh;
    r.visible = 1'b1;
    r.left = 10'(left); r.right = 10'(right);
    r.top = 10'(top); r.bottom = 10'(bot);
    r.depth = 16'(d);
    return r;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall pattern: free-running, light random, or long holds
  int stall_mode = 0, stall_phase = 0, stall_hold = 0;
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_phase = $urandom_range(50, 600);
    end
    stall_phase--;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 99) < 35);
      default: begin
        if (stall_hold == 0) begin
          stall_hold = $urandom_range(1, 40);
          out_stall = ~out_stall;
        end
        stall_hold--;
      end
    endcase
  end

  // Result checking against the oldest expectation
  always @(posedge clk) begin
    sprite_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        e = pending_results.pop_front();
        if (visible !== e.visible) begin
          $error("visible exp %0d got %0d", e.visible, visible); mismatches++;
        end
        if (draw !== e.draw) begin
          $error("draw exp %0d got %0d", e.draw, draw); mismatches++;
        end
        if (texel_index !== e.texel) begin
          $error("texel_index exp %0d got %0d", e.texel, texel_index); mismatches++;
        end
        if (box_left !== e.left) begin
          $error("box_left exp %0d got %0d", e.left, box_left); mismatches++;
        end
        if (box_right !== e.right) begin
          $error("box_right exp %0d got %0d", e.right, box_right); mismatches++;
        end
        if (box_top !== e.top) begin
          $error("box_top exp %0d got %0d", e.top, box_top); mismatches++;
        end
        if (box_bottom !== e.bottom) begin
          $error("box_bottom exp %0d got %0d", e.bottom, box_bottom); mismatches++;
        end
        if (sprite_depth !== e.depth) begin
          $error("sprite_depth exp %0d got %0d", e.depth, sprite_depth); mismatches++;
        end
      end
    end
  end

  // One input transaction, with burst gaps
  task automatic send_item(sprite_item_t it);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
      repeat ($urandom_range(0, 25)) @(negedge clk);
    end
    burst_left--;
    operation = it.op; rel_x = it.rx; rel_y = it.ry; rel_z = it.rz;
    sprite_height = it.hgt; frame_width = it.fw; frame_height = it.fh;
    pixel_x = it.px; pixel_y = it.py; wall_depth = it.wdepth; wall_top = it.wtop;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_sprite(it));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, int value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_VIEW_COS: view_c = longint'($signed(16'(value)));
      REG_VIEW_SIN: view_s = longint'($signed(16'(value)));
      REG_SCREEN_W: scr_w = 11'(value);
      default:      scr_h = 11'(value);
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_view(int c, int s, int w, int h);
    drain_results();
    reg_write(REG_VIEW_COS, c);
    reg_write(REG_VIEW_SIN, s);
    reg_write(REG_SCREEN_W, w);
    reg_write(REG_SCREEN_H, h);
  endtask

  function automatic sprite_item_t mk_setup(int x, int y, int z, int hg, int fw, int fh);
    sprite_item_t it;
    it = '{default: '0};
    it.op = OP_SETUP;
    it.rx = 16'(x); it.ry = 16'(y); it.rz = 16'(z);
    it.hgt = 16'(hg); it.fw = 9'(fw); it.fh = 9'(fh);
    return it;
  endfunction

  function automatic sprite_item_t mk_pixel(int x, int y, int wd, int wt);
    sprite_item_t it;
    it = '{default: '0};
    it.op = OP_PIXEL;
    it.px = 10'(x); it.py = 10'(y); it.wdepth = 16'(wd); it.wtop = 16'(wt);
    return it;
  endfunction

  function automatic sprite_item_t rand_noise();
    sprite_item_t it;
    it.op = 1'($urandom); it.rx = 16'($urandom); it.ry = 16'($urandom);
    it.rz = 16'($urandom); it.hgt = 16'($urandom); it.fw = 9'($urandom);
    it.fh = 9'($urandom); it.px = 10'($urandom); it.py = 10'($urandom);
    it.wdepth = 16'($urandom); it.wtop = 16'($urandom);
    return it;
  endfunction

  // Sprite placed in camera space, rotated into the world by the view
  function automatic sprite_item_t rand_setup();
    int d, lat;
    d = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 300) : $urandom_range(200, 6000);
    lat = $urandom_range(0, 2 * d) - d;
    return mk_setup(clip((d * view_c - lat * view_s) / 16384, -32768, 32767),
                    clip((d * view_s + lat * view_c) / 16384, -32768, 32767),
                    -$urandom_range(0, 600), $urandom_range(32, 1200),
                    $urandom_range(1, 256), $urandom_range(1, 256));
  endfunction

  function automatic sprite_item_t rand_pixel();
    int x, y, wd, wt;
    if (sprite_ok && $urandom_range(0, 5) != 0) begin
      x = bl + $urandom_range(0, br - bl - 1);
      y = bt + $urandom_range(0, bb - bt - 1);
    end else begin
      x = $urandom_range(0, 1023);
      y = $urandom_range(0, 1023);
    end
    wd = clip(bdepth + $urandom_range(0, 512) - 256, 0, 65535);
    wt = clip((bt + $urandom_range(0, bb - bt + 4) - 2) * 256
              + $urandom_range(0, 511) - 256, -32768, 32767);
    return mk_pixel(x, y, wd, wt);
  endfunction

  // Near limit, field extremes, clamping, empty box, wall cases
  task automatic test_directed();
    send_item(mk_pixel(10, 10, 0, 0));              // no sprite yet
    send_item(mk_setup(13, 0, -128, 256, 16, 16));  // exactly at the near limit
    send_item(mk_setup(12, 0, -128, 256, 16, 16));  // just inside it
    send_item(mk_pixel(160, 100, 65535, 0));        // rejected sprite
    send_item(mk_setup(-32768, 0, 0, 256, 16, 16)); // behind
    send_item(mk_setup(512, 32767, 0, 256, 16, 16));  // far to the side: empty
    send_item(mk_setup(512, 0, -128, 256, 0, 511));   // frame sizes clamped
    send_item(mk_setup(32767, -32768, 32767, 65535, 256, 1));
    send_item(mk_setup(512, 0, -32768, 0, 1, 256));   // zero height
    send_item(mk_setup(1024, 100, -200, 400, 64, 32));
    send_item(mk_pixel(bl, bt, 65535, 0));             // corner, wall farther
    send_item(mk_pixel(br - 1, bb - 1, 65535, 0));
    send_item(mk_pixel(br, bt, 65535, 0));             // just outside
    send_item(mk_pixel(bl, bt, 0, bt * 256 + 1));      // wall nearer, above top
    send_item(mk_pixel(bl, bt, 0, bt * 256));          // wall nearer, on top
    send_item(mk_pixel(bl, bt, bdepth, -32768));       // equal depth not nearer
    send_item(mk_pixel(1023, 1023, 0, 32767));
    send_item(mk_setup(300, 0, -32768, 65535, 256, 256));
    send_item(mk_pixel(0, 0, 0, -32768));
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 97 == 96) drain_results();  // hold off until all results are in
      case ($urandom_range(0, 9))
        0, 1:    send_item(rand_setup());
        2:       send_item(rand_noise());
        default: send_item(rand_pixel());
      endcase
    end
  endtask

  // Random traffic under several view and screen settings
  task automatic test_view_sweep();
    set_view(16384, 0, 320, 200);
    test_random(430);
    set_view(-16384, 16384, 1024, 1024);
    test_random(250);
    set_view(0, -16384, 2, 2);
    test_random(150);
    set_view(11585, 11585, 1024, 2);
    test_random(250);
    set_view(16384, -16384, 0, 2047);
    test_random(150);
    set_view(-11585, -11585, 640, 480);
    test_random(300);
    set_view(0, 16384, 2047, 0);
    test_random(150);
  endtask

  initial begin
    view_c = 16384; view_s = 0; scr_w = 320; scr_h = 200;
    bl = 0; br = 0; bt = 0; bb = 0; bdepth = 0; bfw = 1; bfh = 1;
    sprite_ok = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_view_sweep();
    drain_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/bbsp_pkg.sv
hw/rtl/bbsp_div.sv
hw/rtl/bbsp_mul.sv
hw/rtl/billboard_sprite_projection_clip.sv
hw/rtl/bbsp_checker.sv
dv/tb_billboard_sprite_projection_clip.sv
